// ----- sv/tks_pkg.sv -----
// shared types and constants of the topological sorter
// no dependencies; imported by every module of the block but tks_ram
`default_nettype none

package tks_pkg;

  localparam int unsigned VERTEX_W   = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_CNT_VTX,
    ST_CNT_LIST,
    ST_CNT_EDGE,
    ST_CNT_DEG,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_WALK_V,
    ST_WALK_LIST,
    ST_WALK_EDGE,
    ST_WALK_DEG,
    ST_EMIT,
    ST_NONE_RES
  } state_e;

  typedef struct packed {
    logic                edges_dropped;
    logic                all_sorted;
    logic                last;
    logic                vertex_valid;
    logic [VERTEX_W-1:0] vertex;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/tks_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module tks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/tks_out.sv -----
// output register between the sequencer and the result stream
// depends on tks_pkg
`default_nettype none

module tks_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  output logic               res_ready_o,
  input  wire tks_pkg::res_t res_i,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output tks_pkg::res_t      m_res_o
);
  import tks_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // slot is free when empty or being drained this cycle
  assign res_ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

// ----- sv/tks_seq.sv -----
// sequencer: edge list linking, in-degree count, zero-degree scan and stack walk
// depends on tks_pkg; drives the list, edge, degree and stack rams
`default_nettype none

module tks_seq #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 1024,
  localparam int unsigned VW = $clog2(MAX_VERTICES),
  localparam int unsigned NW = VW + 1,
  localparam int unsigned AW = $clog2(MAX_EDGES),
  localparam int unsigned TW = $clog2(MAX_EDGES + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tks_pkg::op_e                  in_op_i,
  input  wire logic [tks_pkg::VERTEX_W-1:0]  in_src_i,
  input  wire logic [tks_pkg::VERTEX_W-1:0]  in_tgt_i,
  input  wire logic [tks_pkg::COUNT_W-1:0]   vertex_count_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output tks_pkg::res_t                      res_o,
  // list ram: {head, tail} per vertex
  output logic                               lst_we_o,
  output logic [VW-1:0]                      lst_waddr_o,
  output logic [2*AW-1:0]                    lst_wdata_o,
  output logic                               lst_re_o,
  output logic [VW-1:0]                      lst_raddr_o,
  input  wire logic [2*AW-1:0]               lst_rdata_i,
  // edge target ram
  output logic                               tgt_we_o,
  output logic [AW-1:0]                      tgt_waddr_o,
  output logic [VW-1:0]                      tgt_wdata_o,
  output logic                               tgt_re_o,
  output logic [AW-1:0]                      tgt_raddr_o,
  input  wire logic [VW-1:0]                 tgt_rdata_i,
  // edge link ram
  output logic                               nxt_we_o,
  output logic [AW-1:0]                      nxt_waddr_o,
  output logic [AW-1:0]                      nxt_wdata_o,
  output logic                               nxt_re_o,
  output logic [AW-1:0]                      nxt_raddr_o,
  input  wire logic [AW-1:0]                 nxt_rdata_i,
  // in-degree ram
  output logic                               deg_we_o,
  output logic [VW-1:0]                      deg_waddr_o,
  output logic [TW-1:0]                      deg_wdata_o,
  output logic                               deg_re_o,
  output logic [VW-1:0]                      deg_raddr_o,
  input  wire logic [TW-1:0]                 deg_rdata_i,
  // ready stack ram
  output logic                               stk_we_o,
  output logic [VW-1:0]                      stk_waddr_o,
  output logic [VW-1:0]                      stk_wdata_o,
  output logic                               stk_re_o,
  output logic [VW-1:0]                      stk_raddr_o,
  input  wire logic [VW-1:0]                 stk_rdata_i
);
  import tks_pkg::*;

  state_e                  state_q, state_d;
  logic [VERTEX_W-1:0]     src_q, src_d, tgt_q, tgt_d;
  logic [NW-1:0]           n_q, n_d, v_q, v_d, sp_q, sp_d, emitted_q, emitted_d;
  logic [AW-1:0]           e_q, e_d, tail_q, tail_d, next_q, next_d;
  logic [VW-1:0]           t_q, t_d;
  logic [TW-1:0]           total_q, total_d;
  logic                    ovf_q, ovf_d;
  logic [MAX_VERTICES-1:0] lvalid_q, lvalid_d, dvalid_q, dvalid_d;

  logic [NW-1:0]  n_sat, sp_dec;
  logic [AW-1:0]  lst_head, lst_tail;
  logic [TW-1:0]  deg_cur;
  logic           full, add_in_range, t_in_n, edge_re;
  logic [AW-1:0]  edge_raddr;

  assign n_sat = (vertex_count_i > COUNT_W'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                           : vertex_count_i[NW-1:0];
  assign sp_dec       = sp_q - NW'(1);
  assign lst_head     = lst_rdata_i[2*AW-1:AW];
  assign lst_tail     = lst_rdata_i[AW-1:0];
  assign full         = (total_q == TW'(MAX_EDGES));
  assign add_in_range = ({1'b0, src_q} < COUNT_W'(MAX_VERTICES)) &&
                        ({1'b0, tgt_q} < COUNT_W'(MAX_VERTICES));
  assign t_in_n       = ({1'b0, tgt_rdata_i} < n_q);
  // never-touched degree entries read as zero
  assign deg_cur      = dvalid_q[t_q] ? deg_rdata_i : '0;

  assign in_ready_o = (state_q == ST_IDLE);

  assign tgt_re_o    = edge_re;
  assign tgt_raddr_o = edge_raddr;
  assign nxt_re_o    = edge_re;
  assign nxt_raddr_o = edge_raddr;

  always_comb begin
    state_d   = state_q;
    src_d     = src_q;
    tgt_d     = tgt_q;
    n_d       = n_q;
    v_d       = v_q;
    sp_d      = sp_q;
    emitted_d = emitted_q;
    e_d       = e_q;
    tail_d    = tail_q;
    next_d    = next_q;
    t_d       = t_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    lvalid_d  = lvalid_q;
    dvalid_d  = dvalid_q;

    lst_we_o    = 1'b0;
    lst_waddr_o = src_q[VW-1:0];
    lst_wdata_o = '0;
    lst_re_o    = 1'b0;
    lst_raddr_o = v_q[VW-1:0];
    tgt_we_o    = 1'b0;
    tgt_waddr_o = total_q[AW-1:0];
    tgt_wdata_o = tgt_q[VW-1:0];
    nxt_we_o    = 1'b0;
    nxt_waddr_o = lst_tail;
    nxt_wdata_o = total_q[AW-1:0];
    edge_re     = 1'b0;
    edge_raddr  = next_q;
    deg_we_o    = 1'b0;
    deg_waddr_o = t_q;
    deg_wdata_o = '0;
    deg_re_o    = 1'b0;
    deg_raddr_o = v_q[VW-1:0];
    stk_we_o    = 1'b0;
    stk_waddr_o = sp_q[VW-1:0];
    stk_wdata_o = t_q;
    stk_re_o    = 1'b0;
    stk_raddr_o = sp_dec[VW-1:0];

    res_valid_o = 1'b0;
    res_o       = '{edges_dropped: ovf_q, all_sorted: 1'b0, last: 1'b0,
                    vertex_valid: 1'b0, vertex: '0};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            OP_ADD: begin
              lst_re_o    = 1'b1;
              lst_raddr_o = in_src_i[VW-1:0];
              src_d       = in_src_i;
              tgt_d       = in_tgt_i;
              state_d     = ST_ADD;
            end
            OP_RUN: begin
              n_d       = n_sat;
              v_d       = '0;
              sp_d      = '0;
              emitted_d = '0;
              dvalid_d  = '0;
              state_d   = ST_CNT_VTX;
            end
            OP_CLEAR: begin
              lvalid_d = '0;
              total_d  = '0;
              ovf_d    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // list entry of the source is on the ram output
      ST_ADD: begin
        state_d = ST_IDLE;
        if (add_in_range) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            tgt_we_o = 1'b1;
            lst_we_o = 1'b1;
            if (lvalid_q[src_q[VW-1:0]]) begin
              nxt_we_o    = 1'b1;
              lst_wdata_o = {lst_head, total_q[AW-1:0]};
            end else begin
              lst_wdata_o = {total_q[AW-1:0], total_q[AW-1:0]};
            end
            lvalid_d[src_q[VW-1:0]] = 1'b1;
            total_d = total_q + TW'(1);
          end
        end
      end

      ST_CNT_VTX: begin
        if (v_q == n_q) begin
          v_d     = '0;
          state_d = ST_SCAN_RD;
        end else begin
          lst_re_o = 1'b1;
          state_d  = ST_CNT_LIST;
        end
      end

      ST_CNT_LIST: begin
        if (lvalid_q[v_q[VW-1:0]]) begin
          e_d        = lst_head;
          tail_d     = lst_tail;
          edge_re    = 1'b1;
          edge_raddr = lst_head;
          state_d    = ST_CNT_EDGE;
        end else begin
          v_d     = v_q + NW'(1);
          state_d = ST_CNT_VTX;
        end
      end

      ST_CNT_EDGE: begin
        next_d = nxt_rdata_i;
        t_d    = tgt_rdata_i;
        if (t_in_n) begin
          deg_re_o    = 1'b1;
          deg_raddr_o = tgt_rdata_i;
          state_d     = ST_CNT_DEG;
        end else if (e_q == tail_q) begin
          v_d     = v_q + NW'(1);
          state_d = ST_CNT_VTX;
        end else begin
          e_d        = nxt_rdata_i;
          edge_re    = 1'b1;
          edge_raddr = nxt_rdata_i;
        end
      end

      ST_CNT_DEG: begin
        deg_we_o       = 1'b1;
        deg_wdata_o    = deg_cur + TW'(1);
        dvalid_d[t_q]  = 1'b1;
        if (e_q == tail_q) begin
          v_d     = v_q + NW'(1);
          state_d = ST_CNT_VTX;
        end else begin
          e_d        = next_q;
          edge_re    = 1'b1;
          state_d    = ST_CNT_EDGE;
        end
      end

      ST_SCAN_RD: begin
        if (v_q == n_q) begin
          state_d = (sp_q == '0) ? ST_NONE_RES : ST_POP;
        end else begin
          deg_re_o = 1'b1;
          state_d  = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (!dvalid_q[v_q[VW-1:0]] || (deg_rdata_i == '0)) begin
          stk_we_o    = 1'b1;
          stk_wdata_o = v_q[VW-1:0];
          sp_d        = sp_q + NW'(1);
        end
        v_d     = v_q + NW'(1);
        state_d = ST_SCAN_RD;
      end

      ST_POP: begin
        stk_re_o = 1'b1;
        sp_d     = sp_dec;
        state_d  = ST_WALK_V;
      end

      ST_WALK_V: begin
        v_d         = {1'b0, stk_rdata_i};
        emitted_d   = emitted_q + NW'(1);
        lst_re_o    = 1'b1;
        lst_raddr_o = stk_rdata_i;
        state_d     = ST_WALK_LIST;
      end

      ST_WALK_LIST: begin
        if (lvalid_q[v_q[VW-1:0]]) begin
          e_d        = lst_head;
          tail_d     = lst_tail;
          edge_re    = 1'b1;
          edge_raddr = lst_head;
          state_d    = ST_WALK_EDGE;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_WALK_EDGE: begin
        next_d = nxt_rdata_i;
        t_d    = tgt_rdata_i;
        if (t_in_n) begin
          deg_re_o    = 1'b1;
          deg_raddr_o = tgt_rdata_i;
          state_d     = ST_WALK_DEG;
        end else if (e_q == tail_q) begin
          state_d = ST_EMIT;
        end else begin
          e_d        = nxt_rdata_i;
          edge_re    = 1'b1;
          edge_raddr = nxt_rdata_i;
        end
      end

      ST_WALK_DEG: begin
        if (deg_cur != '0) begin
          deg_we_o    = 1'b1;
          deg_wdata_o = deg_cur - TW'(1);
          // head became free
          if (deg_cur == TW'(1)) begin
            stk_we_o = 1'b1;
            sp_d     = sp_q + NW'(1);
          end
        end
        if (e_q == tail_q) begin
          state_d = ST_EMIT;
        end else begin
          e_d     = next_q;
          edge_re = 1'b1;
          state_d = ST_WALK_EDGE;
        end
      end

      // result of the popped vertex goes out once its list is walked
      ST_EMIT: begin
        res_valid_o        = 1'b1;
        res_o.vertex       = VERTEX_W'(v_q[VW-1:0]);
        res_o.vertex_valid = 1'b1;
        res_o.last         = (sp_q == '0);
        res_o.all_sorted   = (sp_q == '0) && (emitted_q == n_q);
        if (res_ready_i) begin
          state_d = (sp_q == '0) ? ST_IDLE : ST_POP;
        end
      end

      ST_NONE_RES: begin
        res_valid_o      = 1'b1;
        res_o.last       = 1'b1;
        res_o.all_sorted = (n_q == '0);
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      v_q       <= '0;
      sp_q      <= '0;
      emitted_q <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      lvalid_q  <= '0;
      dvalid_q  <= '0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      v_q       <= v_d;
      sp_q      <= sp_d;
      emitted_q <= emitted_d;
      total_q   <= total_d;
      ovf_q     <= ovf_d;
      lvalid_q  <= lvalid_d;
      dvalid_q  <= dvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    tgt_q  <= tgt_d;
    e_q    <= e_d;
    tail_q <= tail_d;
    next_q <= next_d;
    t_q    <= t_d;
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= NW'(MAX_VERTICES))
    else $error("ready stack deeper than vertex count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> (sp_q != '0))
    else $error("pop from empty ready stack");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(MAX_EDGES))
    else $error("edge count beyond store size");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (emitted_q <= n_q))
    else $error("more vertices emitted than in graph");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && add_in_range && !full) |=> (total_q == $past(total_q) + TW'(1)))
    else $error("stored edge not counted");

endmodule

`default_nettype wire

// ----- sv/topological_sort_kahn_stack.sv -----
// topological sorter, in-degree scheme with a lifo ready stack; add edge and clear give
// no result. a run stalls in its emit step while the output register is not ready, and
// each list, edge, degree and stack access waits out the registered ram read. a new item
// is taken once the run has handed its last result to the output register.
// reset is asynchronous: edge lists empty, flags cleared, vertex_count 64, no sweep.
`default_nettype none

module topological_sort_kahn_stack #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // stream in
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [15:0]                        s_axis_tdata,  // source_vertex, target_vertex
  input  wire logic [1:0]                         s_axis_tuser,  // operation
  // stream out
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [7:0]                              m_axis_tdata,  // vertex
  output logic                                    m_axis_tlast,
  output logic [2:0]                              m_axis_tuser,  // vertex_valid, all_sorted,
                                                                 // edges_dropped
  // register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tks_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [tks_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tks_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                    pready
);
  import tks_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);

  logic [COUNT_W-1:0] vertex_count_q, vertex_count_d;
  logic               cfg_hit;

  logic    res_valid, res_ready;
  res_t    res, m_res;

  logic              lst_we, lst_re;
  logic [VW-1:0]     lst_waddr, lst_raddr;
  logic [2*AW-1:0]   lst_wdata, lst_rdata;
  logic              tgt_we, tgt_re;
  logic [AW-1:0]     tgt_waddr, tgt_raddr;
  logic [VW-1:0]     tgt_wdata, tgt_rdata;
  logic              nxt_we, nxt_re;
  logic [AW-1:0]     nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
  logic              deg_we, deg_re;
  logic [VW-1:0]     deg_waddr, deg_raddr;
  logic [TW-1:0]     deg_wdata, deg_rdata;
  logic              stk_we, stk_re;
  logic [VW-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // register port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_VERTEX_COUNT);
  assign prdata  = cfg_hit ? CFG_DATA_W'(vertex_count_q) : '0;

  always_comb begin
    vertex_count_d = vertex_count_q;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      vertex_count_d = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
    end else begin
      vertex_count_q <= vertex_count_d;
    end
  end

  tks_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (op_e'(s_axis_tuser)),
    .in_src_i       (s_axis_tdata[5:0]),
    .in_tgt_i       (s_axis_tdata[11:6]),
    .vertex_count_i (vertex_count_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .lst_we_o       (lst_we),
    .lst_waddr_o    (lst_waddr),
    .lst_wdata_o    (lst_wdata),
    .lst_re_o       (lst_re),
    .lst_raddr_o    (lst_raddr),
    .lst_rdata_i    (lst_rdata),
    .tgt_we_o       (tgt_we),
    .tgt_waddr_o    (tgt_waddr),
    .tgt_wdata_o    (tgt_wdata),
    .tgt_re_o       (tgt_re),
    .tgt_raddr_o    (tgt_raddr),
    .tgt_rdata_i    (tgt_rdata),
    .nxt_we_o       (nxt_we),
    .nxt_waddr_o    (nxt_waddr),
    .nxt_wdata_o    (nxt_wdata),
    .nxt_re_o       (nxt_re),
    .nxt_raddr_o    (nxt_raddr),
    .nxt_rdata_i    (nxt_rdata),
    .deg_we_o       (deg_we),
    .deg_waddr_o    (deg_waddr),
    .deg_wdata_o    (deg_wdata),
    .deg_re_o       (deg_re),
    .deg_raddr_o    (deg_raddr),
    .deg_rdata_i    (deg_rdata),
    .stk_we_o       (stk_we),
    .stk_waddr_o    (stk_waddr),
    .stk_wdata_o    (stk_wdata),
    .stk_re_o       (stk_re),
    .stk_raddr_o    (stk_raddr),
    .stk_rdata_i    (stk_rdata)
  );

  tks_ram #(.WIDTH(2*AW), .DEPTH(MAX_VERTICES)) u_list_ram (
    .clk_i (clk_i), .we_i (lst_we), .waddr_i (lst_waddr), .wdata_i (lst_wdata),
    .re_i (lst_re), .raddr_i (lst_raddr), .rdata_o (lst_rdata)
  );

  tks_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_target_ram (
    .clk_i (clk_i), .we_i (tgt_we), .waddr_i (tgt_waddr), .wdata_i (tgt_wdata),
    .re_i (tgt_re), .raddr_i (tgt_raddr), .rdata_o (tgt_rdata)
  );

  tks_ram #(.WIDTH(AW), .DEPTH(MAX_EDGES)) u_next_ram (
    .clk_i (clk_i), .we_i (nxt_we), .waddr_i (nxt_waddr), .wdata_i (nxt_wdata),
    .re_i (nxt_re), .raddr_i (nxt_raddr), .rdata_o (nxt_rdata)
  );

  tks_ram #(.WIDTH(TW), .DEPTH(MAX_VERTICES)) u_degree_ram (
    .clk_i (clk_i), .we_i (deg_we), .waddr_i (deg_waddr), .wdata_i (deg_wdata),
    .re_i (deg_re), .raddr_i (deg_raddr), .rdata_o (deg_rdata)
  );

  tks_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk_i (clk_i), .we_i (stk_we), .waddr_i (stk_waddr), .wdata_i (stk_wdata),
    .re_i (stk_re), .raddr_i (stk_raddr), .rdata_o (stk_rdata)
  );

  tks_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata = {2'b00, m_res.vertex};
  assign m_axis_tlast = m_res.last;
  assign m_axis_tuser = {m_res.edges_dropped, m_res.all_sorted, m_res.vertex_valid};

endmodule

`default_nettype wire

// ----- tb/topological_sort_kahn_stack_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for topological_sort_kahn_stack: streams edge, run and clear items,
// predicts each emitted vertex in a scoreboard and compares the output stream field by field
// depends on tks_pkg and the block's rtl only

class sort_checker;
  localparam int unsigned EDGE_CAP = 1024;
  localparam int unsigned VTX_CAP  = 64;

  int unsigned      vcount;
  bit [5:0]         succ[VTX_CAP][$];  // per-tail edge lists in load order
  int unsigned      stored;
  bit               dropped;
  tks_pkg::res_t    order_q[$];        // vertices still owed by the block
  int unsigned      errors;

  function new();
    vcount  = 64;
    stored  = 0;
    dropped = 1'b0;
    errors  = 0;
  endfunction

  function void cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void predict_run();
    int unsigned   n, emitted, depth, v, t;
    int unsigned   indeg[VTX_CAP];
    bit [5:0]      ready_q[VTX_CAP];
    tks_pkg::res_t r;
    bit            have;
    n       = (vcount > VTX_CAP) ? VTX_CAP : vcount;
    emitted = 0;
    depth   = 0;
    have    = 1'b0;
    r       = '0;
    for (v = 0; v < VTX_CAP; v++) indeg[v] = 0;
    for (v = 0; v < n; v++) begin
      for (int j = 0; j < succ[v].size(); j++) begin
        if (succ[v][j] < n) indeg[succ[v][j]]++;
      end
    end
    for (v = 0; v < n; v++) begin
      if (indeg[v] == 0) begin
        ready_q[depth] = v[5:0];
        depth++;
      end
    end
    // lifo: the most recently freed vertex goes out first
    while (depth > 0) begin
      depth--;
      v = ready_q[depth];
      if (have) order_q.push_back(r);
      r               = '0;
      r.vertex        = v[5:0];
      r.vertex_valid  = 1'b1;
      r.edges_dropped = dropped;
      have            = 1'b1;
      emitted++;
      for (int j = 0; j < succ[v].size(); j++) begin
        t = succ[v][j];
        if (t < n && indeg[t] > 0) begin
          indeg[t]--;
          if (indeg[t] == 0) begin
            ready_q[depth] = t[5:0];
            depth++;
          end
        end
      end
    end
    if (!have) begin
      r               = '0;
      r.edges_dropped = dropped;
    end
    r.last       = 1'b1;
    r.all_sorted = (emitted == n);
    order_q.push_back(r);
  endfunction

  function void note_item(logic [1:0] op, logic [5:0] src, logic [5:0] dst);
    case (op)
      tks_pkg::OP_ADD: begin
        if (stored >= EDGE_CAP) begin
          dropped = 1'b1;
        end else begin
          succ[src].push_back(dst);
          stored++;
        end
      end
      tks_pkg::OP_RUN: predict_run();
      tks_pkg::OP_CLEAR: begin
        for (int v = 0; v < VTX_CAP; v++) succ[v].delete();
        stored  = 0;
        dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function void check_vertex(tks_pkg::res_t got);
    tks_pkg::res_t want;
    if (order_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected item, expected none, got vertex %0d valid %0d last %0d",
               $time, got.vertex, got.vertex_valid, got.last);
      return;
    end
    want = order_q.pop_front();
    cmp("vertex", want.vertex, got.vertex);
    cmp("vertex_valid", want.vertex_valid, got.vertex_valid);
    cmp("last", want.last, got.last);
    cmp("all_sorted", want.all_sorted, got.all_sorted);
    cmp("edges_dropped", want.edges_dropped, got.edges_dropped);
  endfunction

  function void flag_leftover();
    foreach (order_q[i]) begin
      errors++;
      $display("%0t: missing item, expected vertex %0d valid %0d last %0d, got none",
               $time, order_q[i].vertex, order_q[i].vertex_valid, order_q[i].last);
    end
  endfunction
endclass

module topological_sort_kahn_stack_tb;
  import tks_pkg::*;

  localparam int unsigned EDGE_CAP      = 1024;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned PHASE_ITEMS   = 62;
  localparam int unsigned DRAIN_LIMIT   = 200000;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // source_vertex, target_vertex
  logic [1:0]            s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // vertex
  logic                  m_axis_tlast;
  logic [2:0]            m_axis_tuser;   // vertex_valid, all_sorted, edges_dropped
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sort_checker   sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_off_req;
  int unsigned   item_count;
  int unsigned   cycle_count;
  bit [5:0]      perm[64];

  topological_sort_kahn_stack #(
    .MAX_VERTICES(64),
    .MAX_EDGES   (EDGE_CAP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: check accepted items, then pick tready for the next cycle
  initial begin
    tks_pkg::res_t got;
    int unsigned   hold_left;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.vertex        = m_axis_tdata[5:0];
        got.vertex_valid  = m_axis_tuser[0];
        got.all_sorted    = m_axis_tuser[1];
        got.edges_dropped = m_axis_tuser[2];
        got.last          = m_axis_tlast;
        sb.check_vertex(got);
      end
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [5:0] src, input logic [5:0] dst);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, dst, src};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(op, src, dst);
    item_count++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.order_q.size() != 0);
  endtask

  // only while idle; adds and clears give no item, so allow them to finish
  task automatic write_vcount(input logic [6:0] val);
    logic [31:0] rnd;
    logic [31:0] rd;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    rnd = $urandom();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_VERTEX_COUNT;
    pwdata  <= {rnd[31:7], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.vcount = 32'(val);
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    sb.cmp("vertex_count readback", val, rd[6:0]);
  endtask

  // mostly forward edges along perm, with some back edges, self loops and strays
  task automatic add_dag_edge(input int unsigned span);
    int unsigned a, b, pick;
    logic [5:0]  src, dst;
    pick = $urandom_range(99);
    if (span < 2 || pick < 3) begin
      src = perm[$urandom_range(span - 1)];
      dst = src;
    end else if (pick < 8) begin
      src = 6'($urandom_range(63));
      dst = 6'($urandom_range(63));
    end else begin
      a   = $urandom_range(span - 2);
      b   = $urandom_range(span - 1, a + 1);
      src = perm[a];
      dst = perm[b];
      if (pick < 16) {src, dst} = {dst, src};
    end
    send_item(OP_ADD, src, dst);
  endtask

  initial begin
    int unsigned target, span, n_edges, pick, waited;
    logic [6:0]  vc;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cycle_count    = 0;
    hold_off_req   = 0;
    item_count     = 0;
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    sb             = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty graph at the reset vertex count: every vertex free, emitted high to low
    send_item(OP_RUN, 6'd0, 6'd0);
    write_vcount(7'd0);
    send_item(OP_RUN, 6'd63, 6'd63);
    write_vcount(7'd1);
    send_item(OP_RUN, 6'd0, 6'd0);
    // count above the vertex limit saturates; two-vertex cycle plus self loop
    write_vcount(7'd127);
    send_item(OP_ADD, 6'd63, 6'd0);
    send_item(OP_ADD, 6'd0, 6'd63);
    send_item(OP_ADD, 6'd5, 6'd5);
    send_item(OP_ADD, 6'd2, 6'd3);
    send_item(OP_ADD, 6'd2, 6'd3);
    send_item(OP_ADD, 6'd1, 6'd2);
    send_item(OP_UNUSED, 6'd63, 6'd63);
    send_item(OP_RUN, 6'd0, 6'd0);
    // edges reaching past the count stay stored but are skipped
    write_vcount(7'd4);
    send_item(OP_RUN, 6'd0, 6'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_ADD, 6'd0, 6'd1);
    send_item(OP_ADD, 6'd1, 6'd0);
    // no free vertex at all
    write_vcount(7'd2);
    send_item(OP_RUN, 6'd0, 6'd0);
    write_vcount(7'd100);
    send_item(OP_RUN, 6'd0, 6'd0);
    send_item(OP_CLEAR, 6'd63, 6'd63);
    send_item(OP_RUN, 6'd0, 6'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (phase == 0) begin
        // receiver holds off while runs keep coming, so the input backs up
        write_vcount(7'd16);
        send_item(OP_CLEAR, 6'd0, 6'd0);
        for (int i = 0; i < 15; i++) send_item(OP_ADD, 6'(i), 6'(i + 1));
        hold_off_req = 600;
        repeat (4) send_item(OP_RUN, 6'd0, 6'd0);
        drain_results();
      end
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        if ($urandom_range(99) < 30) begin
          pick = $urandom_range(99);
          if (pick < 70)      vc = 7'($urandom_range(12, 1));
          else if (pick < 80) vc = 7'd64;
          else if (pick < 85) vc = 7'd0;
          else if (pick < 90) vc = 7'($urandom_range(127, 65));
          else                vc = 7'($urandom_range(63, 13));
          write_vcount(vc);
        end
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(99) < 80)
            send_item(OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
          span = (sb.vcount > 64) ? 64 : sb.vcount;
          if (span == 0) span = 4;
          for (int i = 0; i < 64; i++) perm[i] = 6'(i);
          for (int i = 63; i > 0; i--) begin
            int unsigned j;
            bit [5:0]    tmp;
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          n_edges = $urandom_range((span * 2 > 24) ? 24 : span * 2);
          repeat (n_edges) add_dag_edge(span);
          send_item(OP_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)));
          if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(3, 1)) add_dag_edge(span);
            send_item(OP_RUN, 6'($urandom_range(63)), 6'($urandom_range(63)));
          end
        end else begin
          repeat ($urandom_range(4, 1))
            send_item(2'($urandom_range(3)), 6'($urandom_range(63)),
                      6'($urandom_range(63)));
        end
      end
    end

    // a few trailing runs around a clear at the full vertex count
    write_vcount(7'd64);
    send_item(OP_RUN, 6'd0, 6'd0);
    send_item(OP_ADD, 6'd0, 6'd1);
    send_item(OP_RUN, 6'd0, 6'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_RUN, 6'd0, 6'd0);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.order_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tks_pkg.sv
sv/tks_ram.sv
sv/tks_out.sv
sv/tks_seq.sv
sv/topological_sort_kahn_stack.sv
tb/topological_sort_kahn_stack_tb.sv
